@@ rtl/core/frm_pkg.sv @@
// ----------------------------------------------------------------------------
// frm_pkg
// Shared widths, pipeline depths and constants of the frame orthonormalizer.
// ----------------------------------------------------------------------------
package frm_pkg;

  // Default component width of the input vectors
  localparam int COMP_WIDTH_DEF = 16;

  // Width of every axis component (Q1.14)
  localparam int AXIS_W = 16;

  // Square root iterations, one result bit each
  localparam int SQRT_STEPS = 32;

  // Quotient bits of the divider (unit value needs 15 bits)
  localparam int QUO_BITS = 15;

  // Dividend width: magnitude scaled by 2^(14+k) plus half the root
  localparam int NUM_W = 47;

  // Normalizer depth: magnitude, square, sum, two shift stages,
  // root steps, dividend setup, quotient bits, sign and clamp
  localparam int NORM_LAT = 7 + SQRT_STEPS + QUO_BITS;

  // Cross product depth: products, then differences
  localparam int CROSS_LAT = 2;

  // One in Q1.14
  localparam logic [QUO_BITS-1:0] UNIT_Q = 15'd16384;

endpackage

@@ rtl/core/frm_norm.sv @@
// ----------------------------------------------------------------------------
// frm_norm
// Pipelined vector normalizer: sum of squares, even normalizing shift,
// bit-per-stage integer square root, and bit-per-stage rounded division of
// each component by the root. Result in Q1.14, ok low for a zero vector.
// ----------------------------------------------------------------------------
module frm_norm #(
  parameter int VW = 16,
  parameter int MW = 16
) (
  input  logic                                clk,
  input  logic                                en,
  input  logic signed [VW-1:0]                vin [3],
  output logic signed [frm_pkg::AXIS_W-1:0]   q   [3],
  output logic                                ok
);

  localparam int SW = 2 * MW;
  localparam int SQ = frm_pkg::SQRT_STEPS;
  localparam int QB = frm_pkg::QUO_BITS;
  localparam int NW = frm_pkg::NUM_W;
  localparam int CL = frm_pkg::NORM_LAT - 1;
  localparam int OL = frm_pkg::NORM_LAT - 3;
  localparam int PI = 4 + SQ;

  logic [VW-1:0]  abs_v [3];
  logic [MW-1:0]  mag_c [CL][3];
  logic           neg_c [CL][3];
  logic [SW-1:0]  sq    [3];
  logic [63:0]    ssum;
  logic           ok_c  [OL];
  logic [63:0]    sa_next, sb_next, sa, sb;
  logic [4:0]     ka_next, kb_next, ka;
  logic [4:0]     k_c   [SQ+1];
  logic [63:0]    sx    [SQ];
  logic [63:0]    sr    [SQ];
  logic [31:0]    rq    [QB];
  logic [NW-1:0]  rem   [QB][3];
  logic [QB-1:0]  quo   [QB+1][3];
  logic [5:0]     sh;

  // Take magnitudes of the incoming components
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      abs_v[i] = vin[i][VW-1] ? (~vin[i] + 1'b1) : vin[i];
    end
  end

  // Carry magnitudes and signs down the pipeline
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        mag_c[0][i] <= abs_v[i][MW-1:0];
        neg_c[0][i] <= vin[i][VW-1];
      end
      for (int j = 1; j < CL; j++) begin
        mag_c[j] <= mag_c[j-1];
        neg_c[j] <= neg_c[j-1];
      end
    end
  end

  // Square, then sum; flag a nonzero vector
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        sq[i] <= mag_c[0][i] * mag_c[0][i];
      end
      ssum    <= 64'(sq[0]) + 64'(sq[1]) + 64'(sq[2]);
      ok_c[0] <= |{sq[0], sq[1], sq[2]};
      for (int j = 1; j < OL; j++) begin
        ok_c[j] <= ok_c[j-1];
      end
    end
  end

  // Shift the sum left in bit pairs until one of the top two bits is set
  always_comb begin
    sa_next = ssum;
    ka_next = '0;
    if (sa_next[63:32] == '0) begin
      sa_next = sa_next << 32;
      ka_next = ka_next + 5'd16;
    end
    if (sa_next[63:48] == '0) begin
      sa_next = sa_next << 16;
      ka_next = ka_next + 5'd8;
    end
    if (sa_next[63:56] == '0) begin
      sa_next = sa_next << 8;
      ka_next = ka_next + 5'd4;
    end
    sb_next = sa;
    kb_next = ka;
    if (sb_next[63:60] == '0) begin
      sb_next = sb_next << 4;
      kb_next = kb_next + 5'd2;
    end
    if (sb_next[63:62] == '0) begin
      sb_next = sb_next << 2;
      kb_next = kb_next + 5'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sa     <= sa_next;
      ka     <= ka_next;
      sb     <= sb_next;
      k_c[0] <= kb_next;
      for (int j = 1; j <= SQ; j++) begin
        k_c[j] <= k_c[j-1];
      end
    end
  end

  // Square root, one result bit per stage
  for (genvar j = 0; j < SQ; j++) begin : g_sqrt
    localparam logic [63:0] BIT = 64'(1) << (62 - 2 * j);
    logic [63:0] x_in, r_in, t;
    if (j == 0) begin : g_first
      assign x_in = sb;
      assign r_in = '0;
    end else begin : g_rest
      assign x_in = sx[j-1];
      assign r_in = sr[j-1];
    end
    assign t = r_in + BIT;
    always_ff @(posedge clk) begin
      if (en) begin
        if (x_in >= t) begin
          sx[j] <= x_in - t;
          sr[j] <= (r_in >> 1) + BIT;
        end else begin
          sx[j] <= x_in;
          sr[j] <= r_in >> 1;
        end
      end
    end
  end

  // Build the rounded dividends
  assign sh = 6'(k_c[SQ]) + 6'd14;

  always_ff @(posedge clk) begin
    if (en) begin
      rq[0] <= sr[SQ-1][31:0];
      for (int i = 0; i < 3; i++) begin
        rem[0][i] <= (NW'(mag_c[PI][i]) << sh) + NW'(sr[SQ-1][31:1]);
        quo[0][i] <= '0;
      end
    end
  end

  // Restoring division, one quotient bit per stage
  for (genvar d = 0; d < QB; d++) begin : g_div
    localparam int B = QB - 1 - d;
    logic [NW-1:0] dv;
    assign dv = NW'(rq[d]) << B;
    always_ff @(posedge clk) begin
      if (en) begin
        for (int i = 0; i < 3; i++) begin
          if (rem[d][i] >= dv) begin
            quo[d+1][i] <= quo[d][i] | (QB'(1) << B);
          end else begin
            quo[d+1][i] <= quo[d][i];
          end
        end
      end
    end
    if (d < QB - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          rq[d+1] <= rq[d];
          for (int i = 0; i < 3; i++) begin
            rem[d+1][i] <= (rem[d][i] >= dv) ? rem[d][i] - dv : rem[d][i];
          end
        end
      end
    end
  end

  // Clamp to one and restore the sign
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        logic [QB-1:0]                      qc;
        logic signed [frm_pkg::AXIS_W-1:0]  qv;
        qc = (quo[QB][i] > frm_pkg::UNIT_Q) ? frm_pkg::UNIT_Q : quo[QB][i];
        qv = {1'b0, qc};
        q[i] <= neg_c[CL-1][i] ? -qv : qv;
      end
      ok <= ok_c[OL-1];
    end
  end

endmodule

@@ rtl/core/frame_orthonormalizer.sv @@
// ----------------------------------------------------------------------------
// frame_orthonormalizer
// Builds an orthonormal Q1.14 frame from an up and a forward vector (Q2.13).
// ----------------------------------------------------------------------------
// Accepts one transaction per clock while not stalled and returns its frame
// in order. The path runs through two normalizers in series, each a 32-stage
// square root followed by a 15-stage divider, with a two-stage cross product
// ahead of each. A stall on the frame side while a frame is valid freezes the
// whole pipeline and holds the result; item_stall follows it. A zero forward
// vector, or an up vector that is zero or parallel to forward, sets degenerate
// and zeros all nine axis components.
module frame_orthonormalizer #(
  parameter int COMP_WIDTH = frm_pkg::COMP_WIDTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  output logic               item_stall,
  input  logic signed [15:0] up_x,
  input  logic signed [15:0] up_y,
  input  logic signed [15:0] up_z,
  input  logic signed [15:0] fwd_x,
  input  logic signed [15:0] fwd_y,
  input  logic signed [15:0] fwd_z,
  output logic               frame_valid,
  input  logic               frame_stall,
  output logic signed [15:0] right_x,
  output logic signed [15:0] right_y,
  output logic signed [15:0] right_z,
  output logic signed [15:0] upn_x,
  output logic signed [15:0] upn_y,
  output logic signed [15:0] upn_z,
  output logic signed [15:0] fwdn_x,
  output logic signed [15:0] fwdn_y,
  output logic signed [15:0] fwdn_z,
  output logic               degenerate
);

  localparam int EW = (COMP_WIDTH < 16) ? COMP_WIDTH : 16;
  localparam int AW = frm_pkg::AXIS_W;
  localparam int DL = frm_pkg::CROSS_LAT + frm_pkg::NORM_LAT;
  localparam int VD = 2 + 2 * DL;

  logic              en;
  logic              vld [VD];
  logic signed [15:0] up_se [3], fw_se [3];
  logic signed [15:0] up0 [3], fw0 [3], fw1 [3], fw2 [3];
  logic signed [31:0] p1 [6];
  logic signed [32:0] cr [3];
  logic signed [AW-1:0] fn_a [3], rn_b [3], un_c [3];
  logic               ok_a, ok_b, ok_c;
  logic signed [31:0] p2 [6];
  logic signed [31:0] c2 [3];
  logic signed [AW-1:0] dfn [DL][3];
  logic signed [AW-1:0] drn [DL][3];
  logic               dok [DL];
  logic               all_ok;

  // Advance unless a finished frame is held
  assign en          = !(vld[VD-1] && frame_stall);
  assign item_stall  = !en;
  assign frame_valid = vld[VD-1];

  // Valid bits travel with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int j = 0; j < VD; j++) begin
        vld[j] <= 1'b0;
      end
    end else if (en) begin
      vld[0] <= item_valid;
      for (int j = 1; j < VD; j++) begin
        vld[j] <= vld[j-1];
      end
    end
  end

  // Read each component from its low bits
  assign up_se[0] = 16'($signed(up_x[EW-1:0]));
  assign up_se[1] = 16'($signed(up_y[EW-1:0]));
  assign up_se[2] = 16'($signed(up_z[EW-1:0]));
  assign fw_se[0] = 16'($signed(fwd_x[EW-1:0]));
  assign fw_se[1] = 16'($signed(fwd_y[EW-1:0]));
  assign fw_se[2] = 16'($signed(fwd_z[EW-1:0]));

  // Capture, then form up x forward
  always_ff @(posedge clk) begin
    if (en) begin
      up0   <= up_se;
      fw0   <= fw_se;
      p1[0] <= up0[1] * fw0[2];
      p1[1] <= up0[2] * fw0[1];
      p1[2] <= up0[2] * fw0[0];
      p1[3] <= up0[0] * fw0[2];
      p1[4] <= up0[0] * fw0[1];
      p1[5] <= up0[1] * fw0[0];
      fw1   <= fw0;
      for (int i = 0; i < 3; i++) begin
        cr[i] <= 33'(p1[2*i]) - 33'(p1[2*i+1]);
      end
      fw2   <= fw1;
    end
  end

  frm_norm #(.VW(16), .MW(16)) u_norm_fwd (
    .clk (clk),
    .en  (en),
    .vin (fw2),
    .q   (fn_a),
    .ok  (ok_a)
  );

  frm_norm #(.VW(33), .MW(32)) u_norm_right (
    .clk (clk),
    .en  (en),
    .vin (cr),
    .q   (rn_b),
    .ok  (ok_b)
  );

  // Form forward axis x right axis; hold both axes for the output
  always_ff @(posedge clk) begin
    if (en) begin
      p2[0] <= fn_a[1] * rn_b[2];
      p2[1] <= fn_a[2] * rn_b[1];
      p2[2] <= fn_a[2] * rn_b[0];
      p2[3] <= fn_a[0] * rn_b[2];
      p2[4] <= fn_a[0] * rn_b[1];
      p2[5] <= fn_a[1] * rn_b[0];
      for (int i = 0; i < 3; i++) begin
        c2[i] <= p2[2*i] - p2[2*i+1];
      end
      dfn[0] <= fn_a;
      drn[0] <= rn_b;
      dok[0] <= ok_a && ok_b;
      for (int j = 1; j < DL; j++) begin
        dfn[j] <= dfn[j-1];
        drn[j] <= drn[j-1];
        dok[j] <= dok[j-1];
      end
    end
  end

  frm_norm #(.VW(32), .MW(30)) u_norm_up (
    .clk (clk),
    .en  (en),
    .vin (c2),
    .q   (un_c),
    .ok  (ok_c)
  );

  assign all_ok = dok[DL-1] && ok_c;

  // Register the frame, zeroed when degenerate
  always_ff @(posedge clk) begin
    if (en) begin
      right_x    <= all_ok ? drn[DL-1][0] : '0;
      right_y    <= all_ok ? drn[DL-1][1] : '0;
      right_z    <= all_ok ? drn[DL-1][2] : '0;
      upn_x      <= all_ok ? un_c[0] : '0;
      upn_y      <= all_ok ? un_c[1] : '0;
      upn_z      <= all_ok ? un_c[2] : '0;
      fwdn_x     <= all_ok ? dfn[DL-1][0] : '0;
      fwdn_y     <= all_ok ? dfn[DL-1][1] : '0;
      fwdn_z     <= all_ok ? dfn[DL-1][2] : '0;
      degenerate <= !all_ok;
    end
  end

`ifndef SYNTHESIS
  // A degenerate frame carries only zero axes
  a_degen_zero: assert property (@(posedge clk) disable iff (rst)
    frame_valid && degenerate |->
      right_x == 0 && right_y == 0 && right_z == 0 &&
      upn_x == 0 && upn_y == 0 && upn_z == 0 &&
      fwdn_x == 0 && fwdn_y == 0 && fwdn_z == 0)
    else $error("degenerate frame with nonzero axis");

  // A good frame has a nonzero forward and right axis
  a_axes_nonzero: assert property (@(posedge clk) disable iff (rst)
    frame_valid && !degenerate |->
      (fwdn_x != 0 || fwdn_y != 0 || fwdn_z != 0) &&
      (right_x != 0 || right_y != 0 || right_z != 0))
    else $error("valid frame with zero axis");

  // The x components of each axis stay within one
  a_axis_range: assert property (@(posedge clk) disable iff (rst)
    frame_valid |->
      right_x <= 16384 && right_x >= -16384 &&
      upn_x <= 16384 && upn_x >= -16384 &&
      fwdn_x <= 16384 && fwdn_x >= -16384)
    else $error("axis component beyond unit range");
`endif

endmodule
